// ----- sv/efa_pkg.sv -----
package efa_pkg;

  // default sizes of the count frame
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;

  // field widths
  localparam int COORD_BITS = 8;
  localparam int DIM_BITS   = 9;
  localparam int OUT_BITS   = 16;

  // command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // configuration reset values
  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 9'd240;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 9'd180;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOB = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  polarity;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] pixel_count;
    status_t                    status;
  } out_item_t;

  // per-item control carried into the update stage
  typedef struct packed {
    logic oob;
    logic cmd;
    logic pol;
  } op_t;

endpackage

// ----- sv/efa_ram.sv -----
module efa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/efa_clear.sv -----
module efa_clear #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 clearing,
  output logic [ADDR_BITS-1:0] clear_addr
);

  localparam logic [ADDR_BITS-1:0] LAST_ADDR = '1;

  // sweep every entry once after reset, one write per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_BITS'(1);
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/efa_rmw.sv -----
module efa_rmw
  import efa_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int ADDR_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clearing,
  input  logic [ADDR_BITS-1:0] clear_addr,
  input  logic                 take,
  input  op_t                  take_op,
  input  logic [ADDR_BITS-1:0] take_addr,
  output logic                 hold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic                  s1_valid;
  op_t                   s1_op;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic                  s1_fwd;
  logic [COUNT_BITS-1:0] s1_fwd_data;

  logic                  adv;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] new_val;
  logic [COUNT_BITS-1:0] res_val;
  logic [OUT_BITS-1:0]   res_ext;
  status_t               res_status;
  logic                  we;
  logic [ADDR_BITS-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;

  efa_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(2 ** ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (take),
    .raddr(take_addr),
    .rdata(rdata)
  );

  // update stage moves on when the output register is free or being drained
  assign adv  = s1_valid && (!out_valid || !out_stall);
  assign hold = s1_valid && !adv;

  // current count, taking the write that landed on the same edge as the read
  assign cur = s1_fwd ? s1_fwd_data : rdata;

  // saturating increment or decrement, read and clear, or a zero result for an out-of-bounds pixel
  always_comb begin
    new_val    = cur;
    res_val    = cur;
    res_status = ST_OK;
    if (s1_op.oob) begin
      res_val    = '0;
      res_status = ST_OOB;
    end else if (s1_op.cmd == CMD_READ) begin
      new_val = '0;
    end else if (s1_op.pol) begin
      if (cur == CNT_MAX) begin
        res_status = ST_SAT;
      end else begin
        new_val = cur + CNT_ONE;
      end
      res_val = new_val;
    end else begin
      if (cur == CNT_MIN) begin
        res_status = ST_SAT;
      end else begin
        new_val = cur - CNT_ONE;
      end
      res_val = new_val;
    end
  end

  // low bits of the count, sign extended when the count is narrow
  assign res_ext = OUT_BITS'(signed'(res_val));

  // write back, or the clearing sweep after reset
  assign we    = clearing || (adv && !s1_op.oob);
  assign waddr = clearing ? clear_addr : s1_addr;
  assign wdata = clearing ? '0 : new_val;

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op       <= take_op;
      s1_addr     <= take_addr;
      s1_fwd      <= we && (waddr == take_addr);
      s1_fwd_data <= wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.pixel_count <= res_ext;
      out_data.status      <= res_status;
    end
  end

endmodule

// ----- sv/event_frame_accumulator_unit.sv -----
// Event frame accumulator: keeps a signed count per pixel in one single-port-write,
// registered-read RAM of 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries. An
// accumulate command adds one or subtracts one at (pixel_x, pixel_y) with saturation;
// a read command returns the count and clears the pixel. Pixels outside
// frame_width/frame_height are ignored and reported with status 1. A new item is
// taken every cycle unless out_stall holds a result back: the RAM read is issued on
// transfer, the update and write back happen from the read stage register into the
// output register, and a write to the pixel being read on that same edge is
// forwarded. After reset a clearing sweep writes zero to every entry, one per cycle
// (65536 entries at the default size), while in_stall stays high; configuration
// writes are taken at any time and always complete in the cycle they are offered.
module event_frame_accumulator_unit
  import efa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data
);

  localparam int X_BITS    = $clog2(MAX_WIDTH);
  localparam int Y_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = X_BITS + Y_BITS;

  logic [DIM_BITS-1:0]  frame_width;
  logic [DIM_BITS-1:0]  frame_height;
  logic                 clearing;
  logic [ADDR_BITS-1:0] clear_addr;
  logic                 hold;
  logic                 take;
  logic                 in_bounds;
  logic [31:0]          x_ext;
  logic [31:0]          y_ext;
  logic [ADDR_BITS-1:0] take_addr;
  op_t                  take_op;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_stall = clearing || hold;
  assign take     = in_valid && !in_stall;

  // bounds against the registers and the frame size
  assign x_ext = 32'(in_data.pixel_x);
  assign y_ext = 32'(in_data.pixel_y);
  assign in_bounds = (DIM_BITS'(in_data.pixel_x) < frame_width)
                  && (DIM_BITS'(in_data.pixel_y) < frame_height)
                  && (x_ext < 32'(MAX_WIDTH))
                  && (y_ext < 32'(MAX_HEIGHT));

  assign take_addr   = {y_ext[Y_BITS-1:0], x_ext[X_BITS-1:0]};
  assign take_op.oob = !in_bounds;
  assign take_op.cmd = in_data.cmd;
  assign take_op.pol = in_data.polarity;

  efa_clear #(
    .ADDR_BITS(ADDR_BITS)
  ) u_clear (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .clear_addr(clear_addr)
  );

  efa_rmw #(
    .COUNT_BITS(COUNT_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_rmw (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .clear_addr(clear_addr),
    .take      (take),
    .take_op   (take_op),
    .take_addr (take_addr),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/efa_checker.sv -----
module efa_checker
  import efa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // the clearing sweep blocks input right after reset
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a new result follows an input transfer that went through the read stage register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a transfer");

  // ignored pixels report a zero count
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OOB |-> out_data.pixel_count == '0)
    else $error("out of bounds result with nonzero count");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_OOB
               || out_data.status == ST_SAT)
    else $error("undefined status code");

endmodule

bind event_frame_accumulator_unit efa_checker u_efa_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import efa_pkg::*;

  localparam int FRAME_CELLS = 1 << (2 * COORD_BITS);
  // clearing sweep after reset plus generous headroom
  localparam int WDOG_LIMIT  = 4 * FRAME_CELLS;
  localparam int CNT_MAX     = (1 << (COUNT_BITS_DEF - 1)) - 1;
  localparam int CNT_MIN     = -CNT_MAX - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = REG_FRAME_WIDTH;
  logic [DIM_BITS-1:0] cfg_data = '0;

  // predictor state: bounds registers and the count of every pixel
  logic [DIM_BITS-1:0]        frame_w = FRAME_WIDTH_RST;
  logic [DIM_BITS-1:0]        frame_h = FRAME_HEIGHT_RST;
  logic signed [OUT_BITS-1:0] frame_model [0:FRAME_CELLS-1];

  in_item_t  pending_events[$];
  out_item_t expected_counts[$];

  int  mismatch_cnt = 0;
  int  idle_cycles = 0;
  bit  event_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  next_valid;
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  next_stall;

  event_frame_accumulator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // effective bounds, limited to the frame size
  function automatic int unsigned eff_width();
    return (frame_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : 32'(frame_w);
  endfunction

  function automatic int unsigned eff_height();
    return (frame_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : 32'(frame_h);
  endfunction

  // expected result of one event or read, updating the pixel model
  function automatic out_item_t predict_pixel(in_item_t ev);
    out_item_t res;
    int        idx;
    int        cnt;
    res.pixel_count = '0;
    res.status      = ST_OK;
    if (ev.pixel_x >= eff_width() || ev.pixel_y >= eff_height()) begin
      res.status = ST_OOB;
      return res;
    end
    idx = {ev.pixel_y, ev.pixel_x};
    cnt = frame_model[idx];
    if (ev.cmd == CMD_READ) begin
      frame_model[idx] = '0;
    end else begin
      cnt = ev.polarity ? cnt + 1 : cnt - 1;
      if (cnt > CNT_MAX) begin
        cnt        = CNT_MAX;
        res.status = ST_SAT;
      end else if (cnt < CNT_MIN) begin
        cnt        = CNT_MIN;
        res.status = ST_SAT;
      end
      frame_model[idx] = cnt[OUT_BITS-1:0];
    end
    res.pixel_count = cnt[OUT_BITS-1:0];
    return res;
  endfunction

  // random event or read, mostly on a few hot pixels so counts build up
  function automatic in_item_t rand_event();
    in_item_t    ev;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    w              = eff_width();
    h              = eff_height();
    pick           = $urandom_range(0, 9);
    ev.cmd         = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ACCUM;
    ev.polarity    = 1'($urandom_range(0, 1));
    ev.pixel_x     = COORD_BITS'($urandom_range(0, 255));
    ev.pixel_y     = COORD_BITS'($urandom_range(0, 255));
    if (w == 0 || h == 0 || pick >= 8) begin
      return ev;
    end
    if (pick < 4) begin
      ev.pixel_x = COORD_BITS'($urandom_range(0, ((w < 4) ? w : 4) - 1));
      ev.pixel_y = COORD_BITS'($urandom_range(0, ((h < 4) ? h : 4) - 1));
    end else if (pick < 6) begin
      ev.pixel_x = COORD_BITS'(w - 1 - $urandom_range(0, ((w < 4) ? w : 4) - 1));
      ev.pixel_y = COORD_BITS'(h - 1 - $urandom_range(0, ((h < 4) ? h : 4) - 1));
    end else if (pick == 6) begin
      ev.pixel_x = COORD_BITS'($urandom_range(0, w - 1));
      ev.pixel_y = COORD_BITS'($urandom_range(0, h - 1));
    end else begin
      // just past the right edge, when the width is below 256
      ev.pixel_x = COORD_BITS'((w < 256) ? w : $urandom_range(0, 255));
      ev.pixel_y = COORD_BITS'((h < 256) ? $urandom_range(0, h - 1)
                                         : $urandom_range(0, 255));
    end
    return ev;
  endfunction

  task automatic push_event(logic cmd, int unsigned x, int unsigned y, logic pol);
    in_item_t ev;
    ev.cmd      = cmd;
    ev.pixel_x  = COORD_BITS'(x);
    ev.pixel_y  = COORD_BITS'(y);
    ev.polarity = pol;
    pending_events.push_back(ev);
  endtask

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  task automatic cfg_write(logic idx, logic [DIM_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH) begin
      frame_w = val;
    end else begin
      frame_h = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bounds(int unsigned w, int unsigned h);
    cfg_write(REG_FRAME_WIDTH, DIM_BITS'(w));
    cfg_write(REG_FRAME_HEIGHT, DIM_BITS'(h));
    @(posedge clk);
  endtask

  // wait until every event went in and every count came back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_counts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // event transfer: predict the result
  always @(posedge clk) begin
    event_taken = !rst && in_valid && !in_stall;
    if (event_taken) begin
      expected_counts.push_back(predict_pixel(in_data));
      void'(pending_events.pop_front());
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!in_valid || event_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_events.size() != 0) begin
        next_valid = 1'b1;
        in_data <= pending_events[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver: stall pattern changes mode now and then, plus one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else begin
      case (stall_mode)
        0:       next_stall = 1'b0;
        1:       next_stall = ($urandom_range(0, 3) == 0);
        2:       next_stall = (mode_left % 3 == 0);
        default: next_stall = ($urandom_range(0, 9) < 7);
      endcase
    end
    out_stall <= next_stall;
  end

  // result transfer: compare with the oldest expected count
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count %0d status %0d",
                                  out_data.pixel_count, out_data.status));
      end else begin
        want = expected_counts.pop_front();
        if (out_data.pixel_count !== want.pixel_count) begin
          report_mismatch($sformatf("pixel_count %0d, expected %0d",
                                    out_data.pixel_count, want.pixel_count));
        end
        if (out_data.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int ph;
    for (k = 0; k < FRAME_CELLS; k++) begin
      frame_model[k] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset bounds: accumulate both ways, back-to-back on one pixel, edges
    @(posedge clk);
    push_event(CMD_ACCUM, 0, 0, 1'b1);
    push_event(CMD_ACCUM, 0, 0, 1'b1);
    push_event(CMD_ACCUM, 0, 0, 1'b0);
    push_event(CMD_READ, 0, 0, 1'b1);
    push_event(CMD_READ, 0, 0, 1'b0);
    push_event(CMD_ACCUM, 239, 179, 1'b0);
    push_event(CMD_ACCUM, 240, 0, 1'b1);
    push_event(CMD_ACCUM, 0, 180, 1'b0);
    push_event(CMD_READ, 255, 255, 1'b1);
    push_event(CMD_READ, 239, 179, 1'b0);
    wait_drained();

    // full frame: far corner and an untouched pixel
    set_bounds(256, 256);
    push_event(CMD_ACCUM, 255, 255, 1'b1);
    push_event(CMD_READ, 255, 255, 1'b0);
    push_event(CMD_READ, 128, 64, 1'b1);
    wait_drained();

    // zero width: nothing is in bounds
    set_bounds(0, 511);
    push_event(CMD_ACCUM, 0, 0, 1'b1);
    push_event(CMD_READ, 0, 0, 1'b0);
    wait_drained();

    // single pixel frame
    set_bounds(1, 1);
    push_event(CMD_ACCUM, 0, 0, 1'b0);
    push_event(CMD_ACCUM, 1, 0, 1'b1);
    push_event(CMD_ACCUM, 0, 1, 1'b1);
    push_event(CMD_READ, 0, 0, 1'b1);
    wait_drained();

    // zero height
    set_bounds(511, 0);
    push_event(CMD_ACCUM, 255, 0, 1'b1);
    wait_drained();

    // bounds above the frame size are clipped
    set_bounds(511, 256);
    push_event(CMD_ACCUM, 255, 255, 1'b1);
    push_event(CMD_READ, 255, 255, 1'b0);
    wait_drained();

    // run of increments on one pixel and decrements on another, then read and clear
    set_bounds(256, 256);
    for (k = 0; k < 12; k++) begin
      push_event(CMD_ACCUM, 17, 33, 1'b1);
    end
    push_event(CMD_READ, 17, 33, 1'b0);
    push_event(CMD_READ, 17, 33, 1'b0);
    for (k = 0; k < 12; k++) begin
      push_event(CMD_ACCUM, 200, 100, 1'b0);
    end
    push_event(CMD_READ, 200, 100, 1'b1);
    push_event(CMD_READ, 200, 100, 1'b1);
    wait_drained();

    // random traffic under several bound settings
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_bounds(256, 256);
        1:       set_bounds(32'(FRAME_WIDTH_RST), 32'(FRAME_HEIGHT_RST));
        2:       set_bounds($urandom_range(1, 256), $urandom_range(1, 256));
        3:       set_bounds(4, 3);
        default: set_bounds($urandom_range(0, 511), $urandom_range(0, 511));
      endcase
      if (ph == 0) begin
        hold_req = 1'b1;
      end
      for (k = 0; k < 80; k++) begin
        pending_events.push_back(rand_event());
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/efa_pkg.sv
sv/efa_ram.sv
sv/efa_clear.sv
sv/efa_rmw.sv
sv/event_frame_accumulator_unit.sv
sv/efa_checker.sv
sim/tb_top.sv
